@@ hw/rtl/lpr_pkg.sv @@
// Leaf photosynthesis rate: shared payload types, register map and constants.
// No dependencies.
package lpr_pkg;

  typedef struct packed {
    logic [19:0] co2_inside;
    logic [27:0] oxygen_inside;
    logic [19:0] michaelis_co2;
    logic [27:0] michaelis_oxygen;
    logic [19:0] light_level;
  } sample_t;

  typedef struct packed {
    logic signed [19:0] net_assimilation;
    logic               rubisco_limited;
    logic [19:0]        saturating_light;
    logic               invalid;
  } result_t;

  localparam logic [2:0] REG_MAX_CARBOX = 3'd0;
  localparam logic [2:0] REG_MAX_ELEC   = 3'd1;
  localparam logic [2:0] REG_CURVATURE  = 3'd2;
  localparam logic [2:0] REG_COMP_POINT = 3'd3;
  localparam logic [2:0] REG_DARK_RESP  = 3'd4;

  localparam logic [17:0] RST_MAX_CARBOX = 18'd25600;
  localparam logic [17:0] RST_MAX_ELEC   = 18'd51200;
  localparam logic [15:0] RST_CURVATURE  = 16'd45875;
  localparam logic [15:0] RST_COMP_POINT = 16'd10240;
  localparam logic [13:0] RST_DARK_RESP  = 14'd256;

  // absorbed light term at 2000 units (850 in Q16)
  localparam logic [27:0] I2_AT_2000   = 28'd55705600;
  // smallest Q16 light term whose light level no longer fits 20 bits
  localparam logic [26:0] LIGHT_SAT_I2 = 27'd114085069;
  localparam logic [19:0] LIGHT_MAX    = 20'd1048575;

  // reciprocals, exact for 32-bit operands: /5 with >>34, /10 with >>35, /17 with >>36
  localparam logic [31:0] RECIP_5  = 32'hCCCCCCCD;
  localparam logic [31:0] RECIP_17 = 32'hF0F0F0F1;

endpackage

@@ hw/rtl/lpr_div.sv @@
// Leaf photosynthesis rate: pipelined restoring divider, one quotient bit per stage.
// Requires quotient < 2**QW. Carries a tag alongside. No package dependencies.
module lpr_div #(
  parameter int NW = 48,
  parameter int DW = 28,
  parameter int QW = 48,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic          valid,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  input  logic [SW-1:0] tag,
  output logic          q_valid,
  output logic [QW-1:0] quot,
  output logic [SW-1:0] q_tag
);

  logic          vld [QW+1];
  logic [DW-1:0] rem [QW+1];
  logic [NW-1:0] num [QW+1];
  logic [DW-1:0] den [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [SW-1:0] tg  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0] <= DW'(numer >> QW);
      num[0] <= numer;
      den[0] <= denom;
      quo[0] <= '0;
      tg[0]  <= tag;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem[k], num[k][B]};
      ge    = trial >= {1'b0, den[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k+1] <= ge ? DW'(trial - {1'b0, den[k]}) : DW'(trial);
        num[k+1] <= num[k];
        den[k+1] <= den[k];
        quo[k+1] <= quo[k] | (QW'(ge) << B);
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign q_valid = vld[QW];
  assign quot    = quo[QW];
  assign q_tag   = tg[QW];

endmodule

@@ hw/rtl/lpr_sqrt.sv @@
// Leaf photosynthesis rate: pipelined integer square root, one root bit per stage.
// Floor root of a 2*RW bit radicand; carries a tag. No package dependencies.
module lpr_sqrt #(
  parameter int RW = 29,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic            valid,
  input  logic [2*RW-1:0] radicand,
  input  logic [SW-1:0]   tag,
  output logic            r_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   r_tag
);

  localparam int VW = 2 * RW;

  logic          vld [RW+1];
  logic [VW-1:0] rem [RW+1];
  logic [RW-1:0] rt  [RW+1];
  logic [SW-1:0] tg  [RW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rem[0] <= radicand;
      rt[0]  <= '0;
      tg[0]  <= tag;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [VW:0] sub;
    logic        ge;

    always_comb begin
      sub = ((VW+1)'({rt[k], 1'b0}) | ((VW+1)'(1) << B)) << B;
      ge  = {1'b0, rem[k]} >= sub;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k+1] <= ge ? VW'({1'b0, rem[k]} - sub) : rem[k];
        rt[k+1]  <= rt[k] | (RW'(ge) << B);
        tg[k+1]  <= tg[k];
      end
    end
  end

  assign r_valid = vld[RW];
  assign root    = rt[RW];
  assign r_tag   = tg[RW];

endmodule

@@ hw/rtl/leaf_photosynthesis_rate.sv @@
// Leaf photosynthesis rate, top level: APB register file and the full sample pipeline.
// Depends on lpr_pkg, lpr_div and lpr_sqrt.
//
// One sample is accepted per cycle and one result leaves per cycle while the result side
// does not stall; results come out in order, the latency being set by the chain of
// bit-per-stage divider and square-root pipelines (the electron transport rate at the
// sample's light level and at 2000 units run side by side). A stall on the result side
// freezes the whole pipeline, and sample_stall rises in the same cycle.
module leaf_photosynthesis_rate (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  lpr_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output lpr_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lpr_pkg::*;

  // configuration
  logic [17:0] vcmax;
  logic [17:0] jmax;
  logic [15:0] theta;
  logic [15:0] gstar;
  logic [13:0] rdark;
  logic [25:0] jm;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];
  assign jm     = {jmax, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vcmax <= RST_MAX_CARBOX;
      jmax  <= RST_MAX_ELEC;
      theta <= RST_CURVATURE;
      gstar <= RST_COMP_POINT;
      rdark <= RST_DARK_RESP;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_MAX_CARBOX: vcmax <= pwdata[17:0];
        REG_MAX_ELEC:   jmax  <= pwdata[17:0];
        REG_CURVATURE:  theta <= pwdata[15:0];
        REG_COMP_POINT: gstar <= pwdata[15:0];
        REG_DARK_RESP:  rdark <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_MAX_CARBOX: prdata = 32'(vcmax);
      REG_MAX_ELEC:   prdata = 32'(jmax);
      REG_CURVATURE:  prdata = 32'(theta);
      REG_COMP_POINT: prdata = 32'(gstar);
      REG_DARK_RESP:  prdata = 32'(rdark);
      default:        prdata = '0;
    endcase
  end

  // pipeline control
  logic adv;
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;

  // stage a: input capture
  logic        a_v;
  logic [19:0] a_ci, a_kmc, a_ppfd;
  logic [27:0] a_oi, a_kmo;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= sample_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_ci   <= sample.co2_inside;
      a_oi   <= sample.oxygen_inside;
      a_kmc  <= sample.michaelis_co2;
      a_kmo  <= sample.michaelis_oxygen;
      a_ppfd <= sample.light_level;
    end
  end

  // stage b: Kc*Oi, operand check
  logic        b_v, b_inv;
  logic [47:0] b_mko;
  logic [27:0] b_kmo;
  logic [19:0] b_ci, b_kmc, b_ppfd;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_mko  <= 48'(a_kmc) * 48'(a_oi);
      b_kmo  <= a_kmo;
      b_ci   <= a_ci;
      b_kmc  <= a_kmc;
      b_ppfd <= a_ppfd;
      b_inv  <= (vcmax == '0) || (jmax == '0) || (theta == '0) || (gstar == '0) ||
                (a_ci == '0) || (a_oi == '0) || (a_kmc == '0) || (a_kmo == '0);
    end
  end

  // Kc*Oi/Ko
  logic        da_v, da_inv;
  logic [47:0] da_q;
  logic [19:0] da_ci, da_kmc, da_ppfd;

  lpr_div #(.NW(48), .DW(28), .QW(48), .SW(61)) u_div_ko (
    .clk, .rst, .advance(adv), .valid(b_v), .numer(b_mko), .denom(b_kmo),
    .tag({b_ci, b_kmc, b_ppfd, b_inv}),
    .q_valid(da_v), .quot(da_q), .q_tag({da_ci, da_kmc, da_ppfd, da_inv})
  );

  // stage c: Rubisco denominator and numerator
  logic        c_v, c_inv;
  logic [48:0] c_d;
  logic [37:0] c_vcn;
  logic [19:0] c_ci, c_ppfd;

  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (adv) c_v <= da_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_d    <= 49'(da_ci) + 49'(da_kmc) + 49'(da_q);
      c_vcn  <= 38'(vcmax) * 38'(da_ci);
      c_ci   <= da_ci;
      c_ppfd <= da_ppfd;
      c_inv  <= da_inv;
    end
  end

  // Wc
  logic        db_v, db_inv;
  logic [25:0] db_wc;
  logic [19:0] db_ci, db_ppfd;

  lpr_div #(.NW(46), .DW(49), .QW(26), .SW(41)) u_div_wc (
    .clk, .rst, .advance(adv), .valid(c_v), .numer({c_vcn, 8'b0}), .denom(c_d),
    .tag({c_ci, c_ppfd, c_inv}),
    .q_valid(db_v), .quot(db_wc), .q_tag({db_ci, db_ppfd, db_inv})
  );

  // stage d: PPFD*544
  logic        d_v, d_inv;
  logic [29:0] d_n;
  logic [19:0] d_ci;
  logic [25:0] d_wc;

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= db_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_n   <= 30'({db_ppfd, 9'b0}) + 30'({db_ppfd, 5'b0});
      d_ci  <= db_ci;
      d_wc  <= db_wc;
      d_inv <= db_inv;
    end
  end

  // I2 = PPFD*544/5
  logic        dc_v, dc_inv;
  logic [27:0] dc_i2;
  logic [19:0] dc_ci;
  logic [25:0] dc_wc;

  always_ff @(posedge clk) begin
    if (rst) dc_v <= 1'b0;
    else if (adv) dc_v <= d_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc_i2  <= 28'((62'(d_n) * 62'(RECIP_5)) >> 34);
      dc_ci  <= d_ci;
      dc_wc  <= d_wc;
      dc_inv <= d_inv;
    end
  end

  // stages e..i: hyperbola discriminant, lane 0 at sample light, lane 1 at 2000
  logic [27:0] lane_i2 [2];
  assign lane_i2[0] = dc_i2;
  assign lane_i2[1] = I2_AT_2000;

  logic        e_v, f_v, g_v, h_v, i_v;
  logic        e_inv, f_inv, g_inv, h_inv, i_inv;
  logic [19:0] e_ci, f_ci, g_ci, h_ci, i_ci;
  logic [25:0] e_wc, f_wc, g_wc, h_wc, i_wc;
  logic [28:0] e_s [2], f_s [2], g_s [2], h_s [2], i_s [2];
  logic [53:0] e_p [2], f_p [2], g_p [2], h_p [2], i_p [2];
  logic [57:0] f_sq [2], g_sq [2], h_sq [2];
  logic [55:0] f_pa [2], g_pa [2], h_t [2];
  logic [15:0] g_pb [2];
  logic [57:0] i_disc [2];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= 1'b0;
      f_v <= 1'b0;
      g_v <= 1'b0;
      h_v <= 1'b0;
      i_v <= 1'b0;
    end else if (adv) begin
      e_v <= dc_v;
      f_v <= e_v;
      g_v <= f_v;
      h_v <= g_v;
      i_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_ci <= dc_ci;  e_wc <= dc_wc;  e_inv <= dc_inv;
      f_ci <= e_ci;   f_wc <= e_wc;   f_inv <= e_inv;
      g_ci <= f_ci;   g_wc <= f_wc;   g_inv <= f_inv;
      h_ci <= g_ci;   h_wc <= g_wc;   h_inv <= g_inv;
      i_ci <= h_ci;   i_wc <= h_wc;   i_inv <= h_inv;
      for (int l = 0; l < 2; l++) begin
        e_s[l]    <= 29'(lane_i2[l]) + 29'(jm);
        e_p[l]    <= 54'(lane_i2[l]) * 54'(jm);
        f_sq[l]   <= 58'(e_s[l]) * 58'(e_s[l]);
        f_pa[l]   <= 56'(e_p[l][53:14]) * 56'(theta);
        f_s[l]    <= e_s[l];
        f_p[l]    <= e_p[l];
        g_pb[l]   <= 16'((32'({f_p[l][13:0], 2'b0}) * 32'(theta)) >> 16);
        g_pa[l]   <= f_pa[l];
        g_sq[l]   <= f_sq[l];
        g_s[l]    <= f_s[l];
        g_p[l]    <= f_p[l];
        h_t[l]    <= g_pa[l] + 56'(g_pb[l]);
        h_sq[l]   <= g_sq[l];
        h_s[l]    <= g_s[l];
        h_p[l]    <= g_p[l];
        i_disc[l] <= (h_sq[l] > 58'(h_t[l])) ? h_sq[l] - 58'(h_t[l]) : '0;
        i_s[l]    <= h_s[l];
        i_p[l]    <= h_p[l];
      end
    end
  end

  // square roots
  logic        sq_v, sq_inv;
  logic [28:0] sq_r [2], sq_s [2];
  logic [53:0] sq_p [2];
  logic [19:0] sq_ci;
  logic [25:0] sq_wc;

  lpr_sqrt #(.RW(29), .SW(104)) u_sqrt_0 (
    .clk, .rst, .advance(adv), .valid(i_v), .radicand(i_disc[0]),
    .tag({i_s[0], i_p[0], i_ci, i_inv}),
    .r_valid(sq_v), .root(sq_r[0]), .r_tag({sq_s[0], sq_p[0], sq_ci, sq_inv})
  );

  lpr_sqrt #(.RW(29), .SW(109)) u_sqrt_1 (
    .clk, .rst, .advance(adv), .valid(i_v), .radicand(i_disc[1]),
    .tag({i_s[1], i_p[1], i_wc}),
    .r_valid(), .root(sq_r[1]), .r_tag({sq_s[1], sq_p[1], sq_wc})
  );

  // stage j: hyperbola denominator
  logic        j_v, j_inv;
  logic [29:0] j_den [2];
  logic [53:0] j_p [2];
  logic [19:0] j_ci;
  logic [25:0] j_wc;

  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else if (adv) j_v <= sq_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        j_den[l] <= 30'(sq_s[l]) + 30'(sq_r[l]);
        j_p[l]   <= sq_p[l];
      end
      j_ci  <= sq_ci;
      j_wc  <= sq_wc;
      j_inv <= sq_inv;
    end
  end

  // J for both lanes
  logic        dj_v, dj_inv;
  logic [26:0] dj_j [2];
  logic [19:0] dj_ci;
  logic [25:0] dj_wc;

  lpr_div #(.NW(55), .DW(30), .QW(27), .SW(21)) u_div_j0 (
    .clk, .rst, .advance(adv), .valid(j_v), .numer({j_p[0], 1'b0}), .denom(j_den[0]),
    .tag({j_ci, j_inv}),
    .q_valid(dj_v), .quot(dj_j[0]), .q_tag({dj_ci, dj_inv})
  );

  lpr_div #(.NW(55), .DW(30), .QW(27), .SW(26)) u_div_j1 (
    .clk, .rst, .advance(adv), .valid(j_v), .numer({j_p[1], 1'b0}), .denom(j_den[1]),
    .tag(j_wc),
    .q_valid(), .quot(dj_j[1]), .q_tag(dj_wc)
  );

  // stage k: J*Ci and 4Ci+8Gamma*
  logic        k_v, k_inv;
  logic [46:0] k_jc [2];
  logic [22:0] k_cf;
  logic [19:0] k_ci;
  logic [25:0] k_wc;

  always_ff @(posedge clk) begin
    if (rst) k_v <= 1'b0;
    else if (adv) k_v <= dj_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        k_jc[l] <= 47'(dj_j[l]) * 47'(dj_ci);
      end
      k_cf  <= 23'({dj_ci, 2'b0}) + 23'({gstar, 3'b0});
      k_ci  <= dj_ci;
      k_wc  <= dj_wc;
      k_inv <= dj_inv;
    end
  end

  // Wj for both lanes
  logic        dw_v, dw_inv;
  logic [24:0] dw_wj [2];
  logic [22:0] dw_cf;
  logic [19:0] dw_ci;
  logic [25:0] dw_wc;

  lpr_div #(.NW(47), .DW(23), .QW(25), .SW(44)) u_div_wj0 (
    .clk, .rst, .advance(adv), .valid(k_v), .numer(k_jc[0]), .denom(k_cf),
    .tag({k_ci, k_cf, k_inv}),
    .q_valid(dw_v), .quot(dw_wj[0]), .q_tag({dw_ci, dw_cf, dw_inv})
  );

  lpr_div #(.NW(47), .DW(23), .QW(25), .SW(26)) u_div_wj1 (
    .clk, .rst, .advance(adv), .valid(k_v), .numer(k_jc[1]), .denom(k_cf),
    .tag(k_wc),
    .q_valid(), .quot(dw_wj[1]), .q_tag(dw_wc)
  );

  // stage l: limiting rate selection
  logic        l_v, l_inv, l_rub, l_neg;
  logic [25:0] l_w, l_w2;
  logic [19:0] l_diff, l_ci;
  logic [22:0] l_cf;

  always_ff @(posedge clk) begin
    if (rst) l_v <= 1'b0;
    else if (adv) l_v <= dw_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_rub  <= 26'(dw_wj[0]) >= dw_wc;
      l_w    <= (26'(dw_wj[0]) >= dw_wc) ? dw_wc : 26'(dw_wj[0]);
      l_w2   <= (26'(dw_wj[1]) < dw_wc) ? 26'(dw_wj[1]) : dw_wc;
      l_neg  <= dw_ci < 20'(gstar);
      l_diff <= (dw_ci >= 20'(gstar)) ? dw_ci - 20'(gstar) : 20'(gstar) - dw_ci;
      l_ci   <= dw_ci;
      l_cf   <= dw_cf;
      l_inv  <= dw_inv;
    end
  end

  // stage m: W*|Ci-Gamma*| and 9*Wmin
  logic        m_v, m_inv, m_rub, m_neg;
  logic [45:0] m_mw;
  logic [29:0] m_w9;
  logic [19:0] m_ci;
  logic [22:0] m_cf;

  always_ff @(posedge clk) begin
    if (rst) m_v <= 1'b0;
    else if (adv) m_v <= l_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_mw  <= 46'(l_w) * 46'(l_diff);
      m_w9  <= 30'({l_w2, 3'b0}) + 30'(l_w2);
      m_rub <= l_rub;
      m_neg <= l_neg;
      m_ci  <= l_ci;
      m_cf  <= l_cf;
      m_inv <= l_inv;
    end
  end

  // gross assimilation magnitude
  logic        dm_v, dm_inv, dm_rub, dm_neg;
  logic [41:0] dm_mag;
  logic [29:0] dm_w9;
  logic [19:0] dm_ci;
  logic [22:0] dm_cf;

  lpr_div #(.NW(46), .DW(20), .QW(42), .SW(76)) u_div_mag (
    .clk, .rst, .advance(adv), .valid(m_v), .numer(m_mw), .denom(m_ci),
    .tag({m_w9, m_ci, m_cf, m_rub, m_neg, m_inv}),
    .q_valid(dm_v), .quot(dm_mag), .q_tag({dm_w9, dm_ci, dm_cf, dm_rub, dm_neg, dm_inv})
  );

  // stages n, o: subtract respiration, floor to 8 fraction bits, saturate
  logic               n_v, n_inv, n_rub, o_v, o_inv, o_rub;
  logic signed [43:0] n_a, o_sh;
  logic [29:0]        n_w9, o_w9;
  logic [19:0]        n_ci, o_ci, o_na;
  logic [22:0]        n_cf, o_cf;

  assign o_sh = n_a >>> 8;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
      o_v <= 1'b0;
    end else if (adv) begin
      n_v <= dm_v;
      o_v <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_a   <= (dm_neg ? 44'(0) - 44'(dm_mag) : 44'(dm_mag)) - 44'({rdark, 8'b0});
      n_w9  <= dm_w9;
      n_ci  <= dm_ci;
      n_cf  <= dm_cf;
      n_rub <= dm_rub;
      n_inv <= dm_inv;
      if (o_sh > 44'sd524287) begin
        o_na <= 20'h7FFFF;
      end else if (o_sh < -44'sd524288) begin
        o_na <= 20'h80000;
      end else begin
        o_na <= o_sh[19:0];
      end
      o_w9  <= n_w9;
      o_ci  <= n_ci;
      o_cf  <= n_cf;
      o_rub <= n_rub;
      o_inv <= n_inv;
    end
  end

  // Wsat = 9W/10
  logic        d9_v, d9_inv, d9_rub;
  logic [25:0] d9_ws;
  logic [19:0] d9_na, d9_ci;
  logic [22:0] d9_cf;

  always_ff @(posedge clk) begin
    if (rst) d9_v <= 1'b0;
    else if (adv) d9_v <= o_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d9_ws  <= 26'((62'(o_w9) * 62'(RECIP_5)) >> 35);
      d9_na  <= o_na;
      d9_rub <= o_rub;
      d9_ci  <= o_ci;
      d9_cf  <= o_cf;
      d9_inv <= o_inv;
    end
  end

  // stages p, q: Wsat*(4Ci+8Gamma*) and the unreachable check against Jmax*Ci
  logic        p_v, p_inv, p_rub, q_v, q_inv, q_rub, q_un;
  logic [48:0] p_x, q_x;
  logic [45:0] p_y;
  logic [19:0] p_na, p_ci, q_na, q_ci;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
      q_v <= 1'b0;
    end else if (adv) begin
      p_v <= d9_v;
      q_v <= p_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_x   <= 49'(d9_ws) * 49'(d9_cf);
      p_y   <= 46'(jm) * 46'(d9_ci);
      p_na  <= d9_na;
      p_ci  <= d9_ci;
      p_rub <= d9_rub;
      p_inv <= d9_inv;
      q_un  <= p_x >= 49'(p_y);
      q_x   <= p_x;
      q_na  <= p_na;
      q_ci  <= p_ci;
      q_rub <= p_rub;
      q_inv <= p_inv;
    end
  end

  // Jsat
  logic        ds_v, ds_inv, ds_rub, ds_un;
  logic [25:0] ds_js;
  logic [19:0] ds_na;

  lpr_div #(.NW(49), .DW(20), .QW(26), .SW(23)) u_div_js (
    .clk, .rst, .advance(adv), .valid(q_v), .numer(q_x), .denom(q_ci),
    .tag({q_na, q_rub, q_un, q_inv}),
    .q_valid(ds_v), .quot(ds_js), .q_tag({ds_na, ds_rub, ds_un, ds_inv})
  );

  // stages r..u: light term numerator, denominator and saturation check
  logic        r_v, s_v, t_v, u_v;
  logic        r_inv, s_inv, t_inv, u_inv;
  logic        r_rub, s_rub, t_rub, u_rub;
  logic        r_un, s_un, t_un, u_un, u_ls;
  logic [19:0] r_na, s_na, t_na, u_na;
  logic [25:0] r_tj, r_js, r_jmj, s_jmj, t_jmj, u_jmj;
  logic [51:0] s_num, t_num, u_num;
  logic [52:0] t_kd;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
      s_v <= 1'b0;
      t_v <= 1'b0;
      u_v <= 1'b0;
    end else if (adv) begin
      r_v <= ds_v;
      s_v <= r_v;
      t_v <= s_v;
      u_v <= t_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_tj  <= 26'((42'(theta) * 42'(ds_js)) >> 16);
      r_jmj <= jm - ds_js;
      r_js  <= ds_js;
      s_num <= 52'(r_js) * 52'(jm - r_tj);
      s_jmj <= r_jmj;
      t_kd  <= 53'(LIGHT_SAT_I2) * 53'(s_jmj);
      t_num <= s_num;
      t_jmj <= s_jmj;
      u_ls  <= 53'(t_num) >= t_kd;
      u_num <= t_num;
      u_jmj <= t_jmj;
      r_na <= ds_na;  r_rub <= ds_rub;  r_un <= ds_un;  r_inv <= ds_inv;
      s_na <= r_na;   s_rub <= r_rub;   s_un <= r_un;   s_inv <= r_inv;
      t_na <= s_na;   t_rub <= s_rub;   t_un <= s_un;   t_inv <= s_inv;
      u_na <= t_na;   u_rub <= t_rub;   u_un <= t_un;   u_inv <= t_inv;
    end
  end

  // I2sat
  logic        di_v, di_inv, di_rub, di_un, di_ls;
  logic [26:0] di_i2s;
  logic [19:0] di_na;

  lpr_div #(.NW(52), .DW(26), .QW(27), .SW(24)) u_div_i2s (
    .clk, .rst, .advance(adv), .valid(u_v), .numer(u_num), .denom(u_jmj),
    .tag({u_na, u_rub, u_un, u_ls, u_inv}),
    .q_valid(di_v), .quot(di_i2s), .q_tag({di_na, di_rub, di_un, di_ls, di_inv})
  );

  // stage v: I2sat*5
  logic        v_v, v_inv, v_rub, v_un, v_ls;
  logic [29:0] v_n5;
  logic [19:0] v_na;

  always_ff @(posedge clk) begin
    if (rst) v_v <= 1'b0;
    else if (adv) v_v <= di_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_n5  <= 30'({di_i2s, 2'b0}) + 30'(di_i2s);
      v_na  <= di_na;
      v_rub <= di_rub;
      v_un  <= di_un;
      v_ls  <= di_ls;
      v_inv <= di_inv;
    end
  end

  // PPFDsat = I2sat*5/544, as /32 then /17
  logic        dl_v, dl_inv, dl_rub, dl_un, dl_ls;
  logic [19:0] dl_light, dl_na;

  always_ff @(posedge clk) begin
    if (rst) dl_v <= 1'b0;
    else if (adv) dl_v <= v_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_light <= 20'((57'(v_n5[29:5]) * 57'(RECIP_17)) >> 36);
      dl_na    <= v_na;
      dl_rub   <= v_rub;
      dl_un    <= v_un;
      dl_ls    <= v_ls;
      dl_inv   <= v_inv;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (adv) result_valid <= dl_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.invalid          <= dl_inv;
      result.net_assimilation <= dl_inv ? '0 : dl_na;
      result.rubisco_limited  <= dl_inv ? 1'b0 : dl_rub;
      result.saturating_light <= dl_inv ? '0 : ((dl_un || dl_ls) ? LIGHT_MAX : dl_light);
    end
  end

endmodule
